// ===== rtl/permutation_mutation_engine_unit_defines.svh =====
// ----------------------------------------------------------------------------
// Permutation mutation engine assertion macros
// Shared concurrent-check macros, clocked on clk_i and disabled in reset.
// ----------------------------------------------------------------------------
`ifndef PERMUTATION_MUTATION_ENGINE_UNIT_DEFINES_SVH
`define PERMUTATION_MUTATION_ENGINE_UNIT_DEFINES_SVH

// Check that cons holds in the same cycle as ante
`define PME_ASSERT_SAME(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("pme check failed");

// Check that cons holds in the cycle after ante
`define PME_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("pme check failed");

`endif

// ===== rtl/pme_pkg.sv =====
// ----------------------------------------------------------------------------
// Permutation mutation engine package
// Widths, register map and operation codes shared by the engine files.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package pme_pkg;

  // City and position width; the tour holds one entry per position
  localparam int CITY_W      = 6;
  localparam int MAX_CITIES  = 1 << CITY_W;
  localparam int CNT_W       = CITY_W + 1;
  localparam int MIN_CITIES  = 2;

  // Configuration port
  localparam int APB_DW      = 32;
  localparam int PADDR_W     = 3;
  localparam logic REG_CITY_COUNT = 1'b0;

  typedef enum logic [2:0] {
    OP_FILL          = 3'd0,
    OP_WRITE         = 3'd1,
    OP_READ          = 3'd2,
    OP_PAIR_SWAP     = 3'd3,
    OP_BLOCK_SWAP    = 3'd4,
    OP_BLOCK_SHIFT   = 3'd5,
    OP_BLOCK_REVERSE = 3'd6,
    OP_NONE          = 3'd7
  } op_e;

endpackage

// ===== rtl/pme_ram.sv =====
// ----------------------------------------------------------------------------
// Generic RAM
// One write port and one read port, read data registered.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pme_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 64
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(DEPTH)-1:0] waddr_i,
  input  logic [WIDTH-1:0]         wdata_i,
  input  logic [$clog2(DEPTH)-1:0] raddr_i,
  output logic [WIDTH-1:0]         rdata_o
);

  logic [WIDTH-1:0] mem_q [DEPTH];

  // Write and read in the same cycle; read returns stored data
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_o <= mem_q[raddr_i];
  end

endmodule

// ===== rtl/pme_ring_adv.sv =====
// ----------------------------------------------------------------------------
// Ring position advance
// Steps a tour position by one over the mutable ring 1..last.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module pme_ring_adv import pme_pkg::*; (
  input  logic [CITY_W-1:0] pos_i,
  input  logic [CITY_W-1:0] last_i,
  output logic [CITY_W-1:0] next_o
);

  // Wrap from the last mutable position back to position one
  assign next_o = (pos_i == last_i) ? CITY_W'(1) : CITY_W'(pos_i + 1'b1);

endmodule

// ===== rtl/permutation_mutation_engine_unit.sv =====
// ----------------------------------------------------------------------------
// Permutation mutation engine
// Holds one tour and applies fill, write, read, swap, block swap, block
// shift and block reverse items to it, at most one element access per step.
// ----------------------------------------------------------------------------
// An item is taken when start is high and busy is low; its single result
// shows on done_o for one cycle and must be captured then. Fill, write,
// ignored and out-of-range items answer in the cycle after start; a read
// answers from ST_RD_WAIT once the registered tour data is back. Each step
// of the sequencer does at most one access to the tour memory and at most
// one ring-position advance. A fill clears all valid bits at once: the tour
// has a valid bit per entry and an entry not yet written reads as its own
// position. city_count is written over the APB port at offset 0; the user
// must write it only while idle, and the block itself does not enforce
// this.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`include "permutation_mutation_engine_unit_defines.svh"

module permutation_mutation_engine_unit import pme_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  // item command
  input  logic               start,
  output logic               busy,
  input  logic [2:0]         operation_i,
  input  logic [CITY_W-1:0]  first_index_i,
  input  logic [CITY_W-1:0]  second_index_i,
  input  logic [CITY_W-1:0]  block_length_i,
  input  logic [CITY_W-1:0]  shift_distance_i,
  input  logic [CITY_W-1:0]  write_value_i,
  // result
  output logic               done_o,
  output logic [CITY_W-1:0]  read_value_o,
  output logic               status_o,
  // configuration
  input  logic               psel,
  input  logic               penable,
  input  logic               pwrite,
  input  logic [PADDR_W-1:0] paddr,
  input  logic [APB_DW-1:0]  pwdata,
  output logic [APB_DW-1:0]  prdata,
  output logic               pready
);

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_RD_WAIT,
    ST_WALK,
    ST_SW_RA,
    ST_SW_RB,
    ST_SW_WA,
    ST_SW_WB,
    ST_CP_RD,
    ST_CP_WR,
    ST_MV_RD,
    ST_MV_WR,
    ST_PL_RD,
    ST_PL_WR
  } state_e;

  state_e             state_q, state_d;
  op_e                op_q, op_d;
  logic [CITY_W-1:0]  blen_q, blen_d;
  logic [CITY_W-1:0]  first_q, first_d;
  logic [CITY_W-1:0]  pa_q, pa_d;
  logic [CITY_W-1:0]  pb_q, pb_d;
  logic [CITY_W-1:0]  i_q, i_d;
  logic [CITY_W-1:0]  lim_q, lim_d;
  logic [CITY_W-1:0]  wcnt_q, wcnt_d;
  logic [CITY_W-1:0]  tmp_q, tmp_d;
  logic               done_q, done_d;
  logic [CITY_W-1:0]  rval_q, rval_d;
  logic               status_q, status_d;

  logic [CNT_W-1:0]   city_count_q;
  logic [CNT_W-1:0]   n_eff;
  logic [CITY_W-1:0]  last_pos;
  logic               first_in, start_ok, second_ok, wval_ok;

  logic [MAX_CITIES-1:0] valid_q;
  logic                  valid_clr;
  logic                  rvalid_q;
  logic [CITY_W-1:0]     raddr_q;

  logic               t_we;
  logic [CITY_W-1:0]  t_waddr, t_wdata, t_raddr, t_rdata, tour_rd;
  logic               s_we;
  logic [CITY_W-1:0]  s_waddr, s_wdata, s_raddr, scr_rd;

  logic [CITY_W-1:0]  adv_in, adv_out;

  // Configuration port: zero-wait writes, register read-back
  assign pready = 1'b1;
  assign prdata = (paddr[2] == REG_CITY_COUNT) ?
                  {{(APB_DW-CNT_W){1'b0}}, city_count_q} : '0;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      city_count_q <= CNT_W'(MAX_CITIES);
    end else if (psel && penable && pwrite && pready && paddr[2] == REG_CITY_COUNT) begin
      city_count_q <= pwdata[CNT_W-1:0];
    end
  end

  // Saturate the city count and derive the last ring position
  always_comb begin
    if (city_count_q < CNT_W'(MIN_CITIES)) begin
      n_eff = CNT_W'(MIN_CITIES);
    end else if (city_count_q > CNT_W'(MAX_CITIES)) begin
      n_eff = CNT_W'(MAX_CITIES);
    end else begin
      n_eff = city_count_q;
    end
  end

  assign last_pos  = CITY_W'(n_eff - 1'b1);
  assign first_in  = {1'b0, first_index_i} < n_eff;
  assign start_ok  = first_in && (first_index_i != '0);
  assign second_ok = ({1'b0, second_index_i} < n_eff) && (second_index_i != '0);
  assign wval_ok   = {1'b0, write_value_i} < n_eff;

  // Tour and block scratch memories
  pme_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_tour (
    .clk_i   (clk_i),
    .we_i    (t_we),
    .waddr_i (t_waddr),
    .wdata_i (t_wdata),
    .raddr_i (t_raddr),
    .rdata_o (t_rdata)
  );

  pme_ram #(.WIDTH(CITY_W), .DEPTH(MAX_CITIES)) u_scratch (
    .clk_i   (clk_i),
    .we_i    (s_we),
    .waddr_i (s_waddr),
    .wdata_i (s_wdata),
    .raddr_i (s_raddr),
    .rdata_o (scr_rd)
  );

  // Track entry validity; an unwritten entry reads as its own position
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q  <= '0;
      rvalid_q <= 1'b0;
      raddr_q  <= '0;
    end else begin
      if (valid_clr) begin
        valid_q <= '0;
      end else if (t_we) begin
        valid_q[t_waddr] <= 1'b1;
      end
      rvalid_q <= valid_q[t_raddr];
      raddr_q  <= t_raddr;
    end
  end

  assign tour_rd = rvalid_q ? t_rdata : raddr_q;

  // Shared ring advance: partner pointer in its steps, else the block pointer
  always_comb begin
    case (state_q)
      ST_WALK, ST_SW_WB, ST_MV_WR, ST_PL_WR: adv_in = pb_q;
      default:                               adv_in = pa_q;
    endcase
  end

  pme_ring_adv u_adv (
    .pos_i  (adv_in),
    .last_i (last_pos),
    .next_o (adv_out)
  );

  // Sequencer next state and memory control
  always_comb begin
    state_d   = state_q;
    op_d      = op_q;
    blen_d    = blen_q;
    first_d   = first_q;
    pa_d      = pa_q;
    pb_d      = pb_q;
    i_d       = i_q;
    lim_d     = lim_q;
    wcnt_d    = wcnt_q;
    tmp_d     = tmp_q;
    done_d    = 1'b0;
    rval_d    = rval_q;
    status_d  = status_q;
    valid_clr = 1'b0;
    t_we      = 1'b0;
    t_waddr   = pa_q;
    t_wdata   = tour_rd;
    t_raddr   = pa_q;
    s_we      = 1'b0;
    s_waddr   = i_q;
    s_wdata   = tour_rd;
    s_raddr   = i_q;

    case (state_q)
      ST_IDLE: begin
        if (start) begin
          op_d     = op_e'(operation_i);
          blen_d   = block_length_i;
          first_d  = first_index_i;
          pa_d     = first_index_i;
          pb_d     = first_index_i;
          i_d      = '0;
          lim_d    = block_length_i;
          wcnt_d   = shift_distance_i;
          rval_d   = '0;
          status_d = 1'b0;
          case (op_e'(operation_i))
            OP_FILL: begin
              valid_clr = 1'b1;
              done_d    = 1'b1;
            end
            OP_WRITE: begin
              if (first_in && wval_ok) begin
                t_we    = 1'b1;
                t_waddr = first_index_i;
                t_wdata = write_value_i;
              end else begin
                status_d = 1'b1;
              end
              done_d = 1'b1;
            end
            OP_READ: begin
              if (first_in) begin
                t_raddr = first_index_i;
                state_d = ST_RD_WAIT;
              end else begin
                status_d = 1'b1;
                done_d   = 1'b1;
              end
            end
            OP_PAIR_SWAP: begin
              if (start_ok && second_ok) begin
                pb_d    = second_index_i;
                lim_d   = CITY_W'(1);
                state_d = ST_SW_RA;
              end else begin
                status_d = 1'b1;
                done_d   = 1'b1;
              end
            end
            OP_BLOCK_SWAP: begin
              if (start_ok) begin
                state_d = ST_WALK;
              end else begin
                status_d = 1'b1;
                done_d   = 1'b1;
              end
            end
            OP_BLOCK_SHIFT, OP_BLOCK_REVERSE: begin
              if (start_ok) begin
                state_d = ST_CP_RD;
              end else begin
                status_d = 1'b1;
                done_d   = 1'b1;
              end
            end
            default: begin
              done_d = 1'b1;
            end
          endcase
        end
      end

      // Return the read entry
      ST_RD_WAIT: begin
        rval_d  = tour_rd;
        done_d  = 1'b1;
        state_d = ST_IDLE;
      end

      // Walk the partner pointer forward by the block offset
      ST_WALK: begin
        if (wcnt_q == '0) begin
          state_d = ST_SW_RA;
        end else begin
          pb_d   = adv_out;
          wcnt_d = CITY_W'(wcnt_q - 1'b1);
        end
      end

      // Swap one pair: read both, then write both
      ST_SW_RA: begin
        if (i_q == lim_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          t_raddr = pa_q;
          state_d = ST_SW_RB;
        end
      end
      ST_SW_RB: begin
        t_raddr = pb_q;
        tmp_d   = tour_rd;
        state_d = ST_SW_WA;
      end
      ST_SW_WA: begin
        t_we    = 1'b1;
        t_waddr = pa_q;
        t_wdata = tour_rd;
        pa_d    = adv_out;
        state_d = ST_SW_WB;
      end
      ST_SW_WB: begin
        t_we    = 1'b1;
        t_waddr = pb_q;
        t_wdata = tmp_q;
        pb_d    = adv_out;
        i_d     = CITY_W'(i_q + 1'b1);
        state_d = ST_SW_RA;
      end

      // Copy the block into scratch; the block pointer ends past the block
      ST_CP_RD: begin
        if (i_q == lim_q) begin
          i_d  = '0;
          pb_d = first_q;
          if (op_q == OP_BLOCK_SHIFT) begin
            lim_d   = wcnt_q;
            state_d = ST_MV_RD;
          end else begin
            lim_d   = blen_q;
            state_d = ST_PL_RD;
          end
        end else begin
          t_raddr = pa_q;
          pa_d    = adv_out;
          state_d = ST_CP_WR;
        end
      end
      ST_CP_WR: begin
        s_we    = 1'b1;
        s_waddr = i_q;
        s_wdata = tour_rd;
        i_d     = CITY_W'(i_q + 1'b1);
        state_d = ST_CP_RD;
      end

      // Move the run down over the block
      ST_MV_RD: begin
        if (i_q == lim_q) begin
          i_d     = '0;
          lim_d   = blen_q;
          state_d = ST_PL_RD;
        end else begin
          t_raddr = pa_q;
          pa_d    = adv_out;
          state_d = ST_MV_WR;
        end
      end
      ST_MV_WR: begin
        t_we    = 1'b1;
        t_waddr = pb_q;
        t_wdata = tour_rd;
        pb_d    = adv_out;
        i_d     = CITY_W'(i_q + 1'b1);
        state_d = ST_MV_RD;
      end

      // Place scratch back, reversed for a block reverse
      ST_PL_RD: begin
        if (i_q == lim_q) begin
          done_d  = 1'b1;
          state_d = ST_IDLE;
        end else begin
          if (op_q == OP_BLOCK_REVERSE) begin
            s_raddr = CITY_W'(blen_q - i_q - 1'b1);
          end else begin
            s_raddr = i_q;
          end
          state_d = ST_PL_WR;
        end
      end
      ST_PL_WR: begin
        t_we    = 1'b1;
        t_waddr = pb_q;
        t_wdata = scr_rd;
        pb_d    = adv_out;
        i_d     = CITY_W'(i_q + 1'b1);
        state_d = ST_PL_RD;
      end

      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  // Hold sequencer state and the registered result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q  <= ST_IDLE;
      op_q     <= OP_NONE;
      i_q      <= '0;
      lim_q    <= '0;
      wcnt_q   <= '0;
      done_q   <= 1'b0;
      rval_q   <= '0;
      status_q <= 1'b0;
    end else begin
      state_q  <= state_d;
      op_q     <= op_d;
      i_q      <= i_d;
      lim_q    <= lim_d;
      wcnt_q   <= wcnt_d;
      done_q   <= done_d;
      rval_q   <= rval_d;
      status_q <= status_d;
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    blen_q  <= blen_d;
    first_q <= first_d;
    pa_q    <= pa_d;
    pb_q    <= pb_d;
    tmp_q   <= tmp_d;
  end

  assign busy         = (state_q != ST_IDLE);
  assign done_o       = done_q;
  assign read_value_o = rval_q;
  assign status_o     = status_q;

  // Checks
  `PME_ASSERT_SAME(a_loop_bound, 1'b1, i_q <= lim_q)
  `PME_ASSERT_SAME(a_reject_zero, done_o && status_o, read_value_o == '0)
  `PME_ASSERT_NEXT(a_accept_progress, start && !busy, busy || done_o)
  `PME_ASSERT_NEXT(a_read_reply, state_q == ST_RD_WAIT, done_o && !busy)

endmodule

// ===== bench/permutation_mutation_engine_unit_tb.sv =====
// ----------------------------------------------------------------------------
// Permutation mutation engine testbench
// Drives fill, write, read, swap, block swap, block shift and block reverse
// items at several city counts, tracks the expected tour, and checks each
// result strobe against the oldest outstanding expectation.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module permutation_mutation_engine_unit_tb import pme_pkg::*; ();

  localparam int STALL_LIMIT  = 4000;
  localparam int DRAIN_CYCLES = 400;
  localparam int PHASE_ITEMS  = 130;

  typedef struct packed {
    logic [CITY_W-1:0] read_value;
    logic              status;
  } tour_result_t;

  // Track the tour and the city count; queue one expected result per item
  class tour_tracker;
    bit [CITY_W-1:0] tour_q[MAX_CITIES];
    bit [CNT_W-1:0]  city_count;
    tour_result_t    pending_results[$];
    int              errors;

    function new();
      int i;
      city_count = CNT_W'(MAX_CITIES);
      for (i = 0; i < MAX_CITIES; i++) tour_q[i] = i[CITY_W-1:0];
      errors = 0;
    endfunction

    function int unsigned eff_count();
      if (city_count < MIN_CITIES) return MIN_CITIES;
      if (city_count > MAX_CITIES) return MAX_CITIES;
      return city_count;
    endfunction

    // Fold a position p >= 1 onto the ring 1..n-1
    function int unsigned wrap_pos(int unsigned p, int unsigned n);
      return ((p - 1) % (n - 1)) + 1;
    endfunction

    function void swap_pos(int unsigned a, int unsigned b);
      bit [CITY_W-1:0] hold;
      hold      = tour_q[a];
      tour_q[a] = tour_q[b];
      tour_q[b] = hold;
    endfunction

    // Apply one accepted item to the tour and queue its result
    function void apply_item(logic [2:0] op, logic [CITY_W-1:0] first,
                             logic [CITY_W-1:0] second, logic [CITY_W-1:0] blen,
                             logic [CITY_W-1:0] shift_dist, logic [CITY_W-1:0] wval);
      tour_result_t    res;
      bit [CITY_W-1:0] scratch[MAX_CITIES];
      int unsigned     n, f, s, bl, d, i;
      bit              start_ok;
      n        = eff_count();
      f        = first;
      s        = second;
      bl       = blen;
      d        = shift_dist;
      res      = '0;
      start_ok = (f >= 1) && (f < n);
      case (op_e'(op))
        OP_FILL: begin
          for (i = 0; i < MAX_CITIES; i++) tour_q[i] = i[CITY_W-1:0];
        end
        OP_WRITE: begin
          if (f < n && wval < n) tour_q[f] = wval;
          else res.status = 1'b1;
        end
        OP_READ: begin
          if (f < n) res.read_value = tour_q[f];
          else res.status = 1'b1;
        end
        OP_PAIR_SWAP: begin
          if (start_ok && s >= 1 && s < n) begin
            if (f != s) swap_pos(f, s);
          end else begin
            res.status = 1'b1;
          end
        end
        OP_BLOCK_SWAP: begin
          if (!start_ok) res.status = 1'b1;
          else
            for (i = 0; i < bl; i++)
              swap_pos(wrap_pos(f + i, n), wrap_pos(f + i + d, n));
        end
        OP_BLOCK_SHIFT: begin
          if (!start_ok) begin
            res.status = 1'b1;
          end else begin
            for (i = 0; i < bl; i++) scratch[i] = tour_q[wrap_pos(f + i, n)];
            for (i = 0; i < d; i++)
              tour_q[wrap_pos(f + i, n)] = tour_q[wrap_pos(f + i + bl, n)];
            for (i = 0; i < bl; i++) tour_q[wrap_pos(f + i + d, n)] = scratch[i];
          end
        end
        OP_BLOCK_REVERSE: begin
          if (!start_ok) begin
            res.status = 1'b1;
          end else begin
            for (i = 0; i < bl; i++) scratch[i] = tour_q[wrap_pos(f + i, n)];
            for (i = 0; i < bl; i++) tour_q[wrap_pos(f + i, n)] = scratch[bl - 1 - i];
          end
        end
        default: ;
      endcase
      pending_results.push_back(res);
    endfunction

    // Compare one result strobe with the oldest expectation
    function void compare_result(logic [CITY_W-1:0] read_value, logic status);
      tour_result_t exp_res;
      if (pending_results.size() == 0) begin
        $error("result strobe with no item outstanding");
        errors++;
        return;
      end
      exp_res = pending_results.pop_front();
      if (read_value !== exp_res.read_value) begin
        $error("read_value: expected %0d, got %0d", exp_res.read_value, read_value);
        errors++;
      end
      if (status !== exp_res.status) begin
        $error("status: expected %0d, got %0d", exp_res.status, status);
        errors++;
      end
    endfunction
  endclass

  logic               clk_i            = 1'b0;
  logic               rst_ni           = 1'b0;
  logic               start            = 1'b0;
  logic               busy;
  logic [2:0]         operation_i      = '0;
  logic [CITY_W-1:0]  first_index_i    = '0;
  logic [CITY_W-1:0]  second_index_i   = '0;
  logic [CITY_W-1:0]  block_length_i   = '0;
  logic [CITY_W-1:0]  shift_distance_i = '0;
  logic [CITY_W-1:0]  write_value_i    = '0;
  logic               done_o;
  logic [CITY_W-1:0]  read_value_o;
  logic               status_o;
  logic               psel             = 1'b0;
  logic               penable          = 1'b0;
  logic               pwrite           = 1'b0;
  logic [PADDR_W-1:0] paddr            = '0;
  logic [APB_DW-1:0]  pwdata           = '0;
  logic [APB_DW-1:0]  prdata;
  logic               pready;

  tour_tracker tracker = new();
  int          idle_cycles = 0;
  bit          burst_mode = 1'b0;

  permutation_mutation_engine_unit dut (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .start           (start),
    .busy            (busy),
    .operation_i     (operation_i),
    .first_index_i   (first_index_i),
    .second_index_i  (second_index_i),
    .block_length_i  (block_length_i),
    .shift_distance_i(shift_distance_i),
    .write_value_i   (write_value_i),
    .done_o          (done_o),
    .read_value_o    (read_value_o),
    .status_o        (status_o),
    .psel            (psel),
    .penable         (penable),
    .pwrite          (pwrite),
    .paddr           (paddr),
    .pwdata          (pwdata),
    .prdata          (prdata),
    .pready          (pready)
  );

  always #6 clk_i = ~clk_i;

  // Note accepted items, check result strobes, and watch for a stall
  always @(posedge clk_i) begin
    if (rst_ni) begin
      if (start && !busy)
        tracker.apply_item(operation_i, first_index_i, second_index_i,
                           block_length_i, shift_distance_i, write_value_i);
      if (done_o) tracker.compare_result(read_value_o, status_o);
      if ((start && !busy) || done_o || (psel && penable && pready)) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("Testbench completed WITH ERRORS");
        $finish;
      end
    end
  end

  // Mostly short gaps, a few long ones; none during a burst phase
  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (burst_mode || r < 50) return 0;
    if (r < 88) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  // Mostly a legal ring position, sometimes zero or anything
  function automatic logic [CITY_W-1:0] pick_pos(int unsigned n);
    int r;
    r = $urandom_range(0, 99);
    if (r < 80) return CITY_W'($urandom_range(1, n - 1));
    if (r < 88) return '0;
    return CITY_W'($urandom_range(0, MAX_CITIES - 1));
  endfunction

  function automatic logic [CITY_W-1:0] pick_span(int unsigned n);
    if ($urandom_range(0, 99) < 80) return CITY_W'($urandom_range(0, (n < 8) ? n : 8));
    return CITY_W'($urandom_range(0, MAX_CITIES - 1));
  endfunction

  // Present one item after a gap and hold it until the block takes it
  task automatic send_item(op_e op, logic [CITY_W-1:0] first, logic [CITY_W-1:0] second,
                           logic [CITY_W-1:0] blen, logic [CITY_W-1:0] shift_dist,
                           logic [CITY_W-1:0] wval);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      start <= 1'b0;
      repeat (gap) @(posedge clk_i);
    end
    start            <= 1'b1;
    operation_i      <= op;
    first_index_i    <= first;
    second_index_i   <= second;
    block_length_i   <= blen;
    shift_distance_i <= shift_dist;
    write_value_i    <= wval;
    forever begin
      @(posedge clk_i);
      if (!busy) break;
    end
  endtask

  // Drop start and wait until every result is in and the block is idle
  task automatic drain_items();
    start <= 1'b0;
    do @(posedge clk_i); while (tracker.pending_results.size() != 0 || busy);
  endtask

  // Write city_count over APB, then read it back
  task automatic set_city_count(logic [CNT_W-1:0] count);
    logic [APB_DW-1:0] word;
    word             = $urandom();
    word[CNT_W-1:0]  = count;
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= {REG_CITY_COUNT, 2'b00};
    pwdata  <= word;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    tracker.city_count = count;
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
    psel    <= 1'b1;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    if (prdata[CNT_W-1:0] !== count) begin
      $error("city_count: expected %0d, got %0d", count, prdata[CNT_W-1:0]);
      tracker.errors++;
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk_i);
  endtask

  // Random items at the current city count
  task automatic run_random(int count);
    int          k, r;
    int unsigned n;
    op_e         op;
    n = tracker.eff_count();
    for (k = 0; k < count; k++) begin
      r = $urandom_range(0, 99);
      if (r < 4) op = OP_FILL;
      else if (r < 14) op = OP_WRITE;
      else if (r < 30) op = OP_READ;
      else if (r < 47) op = OP_PAIR_SWAP;
      else if (r < 63) op = OP_BLOCK_SWAP;
      else if (r < 80) op = OP_BLOCK_SHIFT;
      else if (r < 97) op = OP_BLOCK_REVERSE;
      else op = OP_NONE;
      send_item(op, pick_pos(n), pick_pos(n), pick_span(n), pick_span(n),
                ($urandom_range(0, 99) < 85) ? CITY_W'($urandom_range(0, n - 1))
                                             : CITY_W'($urandom_range(0, MAX_CITIES - 1)));
    end
  endtask

  initial begin
    logic [CNT_W-1:0] counts[$];
    int               p;
    counts = '{7'd2, 7'd3, 7'd0, 7'd4, 7'd1, 7'd127, 7'd65, 7'd7, 7'd16, 7'd33,
               7'd63, 7'd64};
    counts.push_back(CNT_W'($urandom_range(2, MAX_CITIES)));

    // Hold reset low before releasing it
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    set_city_count(CNT_W'(MAX_CITIES));

    // Directed items: field extremes, every operation, wrap and ignore cases
    send_item(OP_READ,          6'd0,  6'd0,  6'd0,  6'd0,  6'd0);
    send_item(OP_READ,          6'd63, 6'd0,  6'd0,  6'd0,  6'd0);
    send_item(OP_WRITE,         6'd63, 6'd0,  6'd0,  6'd0,  6'd63);
    send_item(OP_WRITE,         6'd0,  6'd0,  6'd0,  6'd0,  6'd0);
    send_item(OP_PAIR_SWAP,     6'd1,  6'd63, 6'd0,  6'd0,  6'd0);
    send_item(OP_PAIR_SWAP,     6'd5,  6'd5,  6'd0,  6'd0,  6'd0);
    send_item(OP_PAIR_SWAP,     6'd0,  6'd4,  6'd0,  6'd0,  6'd0);
    send_item(OP_PAIR_SWAP,     6'd4,  6'd0,  6'd0,  6'd0,  6'd0);
    send_item(OP_BLOCK_SWAP,    6'd1,  6'd0,  6'd63, 6'd63, 6'd0);
    send_item(OP_BLOCK_SWAP,    6'd0,  6'd0,  6'd3,  6'd2,  6'd0);
    send_item(OP_BLOCK_SWAP,    6'd60, 6'd0,  6'd10, 6'd5,  6'd0);
    send_item(OP_BLOCK_SHIFT,   6'd63, 6'd0,  6'd63, 6'd0,  6'd0);
    send_item(OP_BLOCK_SHIFT,   6'd2,  6'd0,  6'd0,  6'd63, 6'd0);
    send_item(OP_BLOCK_SHIFT,   6'd50, 6'd0,  6'd20, 6'd30, 6'd0);
    send_item(OP_BLOCK_REVERSE, 6'd1,  6'd0,  6'd63, 6'd0,  6'd0);
    send_item(OP_BLOCK_REVERSE, 6'd40, 6'd0,  6'd0,  6'd0,  6'd0);
    send_item(OP_BLOCK_REVERSE, 6'd55, 6'd0,  6'd30, 6'd0,  6'd0);
    send_item(OP_NONE,          6'd63, 6'd63, 6'd63, 6'd63, 6'd63);
    send_item(OP_READ,          6'd63, 6'd0,  6'd0,  6'd0,  6'd0);
    send_item(OP_FILL,          6'd0,  6'd0,  6'd0,  6'd0,  6'd0);
    send_item(OP_READ,          6'd63, 6'd0,  6'd0,  6'd0,  6'd0);
    drain_items();

    // Random phases over a spread of city counts, every third one a burst phase
    for (p = 0; p < counts.size(); p++) begin
      set_city_count(counts[p]);
      burst_mode = (p % 3 == 1);
      run_random(PHASE_ITEMS);
      drain_items();
    end

    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (tracker.pending_results.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_results.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

// ===== filelist.f =====
+incdir+rtl
rtl/pme_pkg.sv
rtl/pme_ram.sv
rtl/pme_ring_adv.sv
rtl/permutation_mutation_engine_unit.sv
bench/permutation_mutation_engine_unit_tb.sv
